/* design/ffg_pkg.sv */
package ffg_pkg;

  localparam int unsigned TICKS_PER_BATCH = 100;
  localparam int unsigned NUM_W = 48;
  localparam int unsigned DEN_W = 27;
  localparam int unsigned STEP_W = 6;

  localparam logic [7:0] MODEL_SMALL   = 8'd1;
  localparam logic [7:0] MODEL_2       = 8'd2;
  localparam logic [7:0] MODEL_3       = 8'd3;
  localparam logic [7:0] MODEL_5       = 8'd5;
  localparam logic [7:0] MODEL_6       = 8'd6;
  localparam logic [7:0] MODEL_7       = 8'd7;
  localparam logic [7:0] MODEL_8       = 8'd8;
  localparam logic [7:0] MODEL_LARGE   = 8'd9;
  localparam logic [7:0] MODEL_10      = 8'd10;
  localparam logic [7:0] MODEL_11      = 8'd11;

  localparam logic [7:0] REV_5ML = 8'd1;
  localparam logic [7:0] REV_1ML = 8'd2;

  localparam logic [1:0] OPT_FIXED  = 2'd0;
  localparam logic [1:0] OPT_ADD_ON = 2'd1;

  localparam logic [2:0] ADDR_SPLITTER = 3'd0;
  localparam logic [2:0] ADDR_OPTION   = 3'd4;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } ffg_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } ffg_div_rsp_t;

  typedef struct packed {
    logic       splitter_present;
    logic [1:0] large_tank_level_option;
  } ffg_cfg_t;

endpackage

/* design/ffg_div.sv */
module ffg_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ffg_pkg::ffg_div_req_t req,
  output ffg_pkg::ffg_div_rsp_t rsp
);

  logic                        busy_r;
  logic                        done_r;
  logic [ffg_pkg::STEP_W-1:0]  cnt_r;
  logic [ffg_pkg::NUM_W-1:0]   num_r;
  logic [ffg_pkg::NUM_W-1:0]   quo_r;
  logic [ffg_pkg::DEN_W-1:0]   den_r;
  logic [ffg_pkg::DEN_W-1:0]   rem_r;
  logic [ffg_pkg::DEN_W-1:0]   rem_nxt;
  logic [ffg_pkg::DEN_W:0]     trial;
  logic                        ge;

  always_comb begin
    trial = {rem_r, num_r[ffg_pkg::NUM_W-1]};
    ge = trial >= {1'b0, den_r};
    if (ge) begin
      rem_nxt = ffg_pkg::DEN_W'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[ffg_pkg::DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= req.steps;
        num_r <= req.num;
        den_r <= req.den;
        rem_r <= '0;
        quo_r <= '0;
      end else if (busy_r) begin
        num_r <= {num_r[ffg_pkg::NUM_W-2:0], 1'b0};
        rem_r <= rem_nxt;
        quo_r <= {quo_r[ffg_pkg::NUM_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ffg_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

/* design/ffg_regs.sv */
module ffg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ffg_pkg::ffg_cfg_t cfg
);

  logic       splitter_r;
  logic [1:0] option_r;
  logic       wr;

  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      splitter_r <= 1'b0;
      option_r <= 2'd0;
    end else if (wr) begin
      if (paddr[2] == ffg_pkg::ADDR_SPLITTER[2]) begin
        splitter_r <= pwdata[0];
      end else begin
        option_r <= pwdata[1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ffg_pkg::ADDR_OPTION[2]) begin
      prdata = {30'd0, option_r};
    end else begin
      prdata = {31'd0, splitter_r};
    end
  end

  assign cfg.splitter_present = splitter_r;
  assign cfg.large_tank_level_option = option_r;

endmodule

/* design/fuel_flow_gauge_core.sv */
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_stall    tick samples and cartridge data
// out_     output     out_valid/out_stall  gauge and level report
// cfg      input      psel/penable/pwrite  splitter and large tank option
//
// A tick holds the input while it is in work; the runtime update runs only with nonzero
// pump flow, the percent divide is skipped when the model has no capacity, and a batch
// boundary adds the fold. The shared restoring divider (one quotient bit a cycle) does
// percent in 23 steps, runtime in 48 steps; the batch fold is a reciprocal multiply.
// A self-test tick is dropped in its transfer cycle. Reset is synchronous.
// in_stall is high while a tick is in work or its result waits for the output register.
module fuel_flow_gauge_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_test_mode,
  input  logic [15:0] in_pump_flow,
  input  logic [15:0] in_burner_flow,
  input  logic [7:0]  in_cartridge_model,
  input  logic [7:0]  in_data_revision,
  input  logic [7:0]  in_old_level_byte,
  input  logic [7:0]  in_level_low_byte,
  input  logic [7:0]  in_level_high_byte,
  input  logic        in_reprogram_pending,
  input  logic        in_empty_error_set,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_decrement_fuel,
  output logic [23:0] out_dispensed_count,
  output logic [15:0] out_fuel_left,
  output logic [7:0]  out_percent_left,
  output logic [16:0] out_full_level,
  output logic        out_adapter_used,
  output logic        out_large_cartridge,
  output logic        out_reprogram_done,
  output logic        out_clear_empty_error,
  output logic [20:0] out_runtime_left,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_FOLD, S_UNITS, S_PCT, S_MUL1, S_MUL2, S_RTGO, S_RT
  } state_t;

  localparam logic [6:0] TICKS = 7'(ffg_pkg::TICKS_PER_BATCH);
  localparam logic [20:0] RUNTIME_MAX = 21'd1280000;
  // ceil(2^22/9): acc/576 = (((acc >> 6) * FOLD_RECIP) >> 22)
  localparam logic [18:0] FOLD_RECIP = 19'd466034;

  state_t state_r;
  logic   finish_r;

  ffg_pkg::ffg_cfg_t     cfg;
  ffg_pkg::ffg_div_req_t div_req;
  ffg_pkg::ffg_div_rsp_t div_rsp;

  logic [23:0] sum_r;
  logic [6:0]  tick_r;
  logic [31:0] gauge_units_r;
  logic [31:0] display_units_r;
  logic [23:0] dispensed_r;
  logic [20:0] avg_r;
  logic [16:0] full_level_r;

  logic [24:0] fold_num_r;
  logic [14:0] fold_q_r;
  logic [15:0] pump_r;
  logic [7:0]  model_r;
  logic [7:0]  rev_r;
  logic        pending_r;
  logic        err_r;
  logic [15:0] fuel_r;
  logic [14:0] cap_r;
  logic        adapter_r;
  logic        dec_r;
  logic [7:0]  pct_r;
  logic [31:0] p1_r;
  logic [47:0] p2_r;

  logic        accept;
  logic [16:0] flow;
  logic [23:0] sum_nxt;
  logic [6:0]  tick_nxt;
  logic [24:0] fold_num;
  logic [37:0] fold_prod;
  logic [15:0] level;
  logic [15:0] fuel_c;
  logic [14:0] cap_c;
  logic [16:0] full_c;
  logic        adapter_c;
  logic [22:0] pct_num;
  logic [31:0] gu;
  logic [31:0] du;
  logic        done_c;
  logic        clr_c;

  ffg_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  ffg_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign in_stall = (state_r != S_IDLE) || finish_r;
  assign accept = in_valid && !in_stall && !in_test_mode;

  always_comb begin
    flow = {1'b0, in_pump_flow} + ((in_burner_flow > 16'd80) ? {1'b0, in_burner_flow} : 17'd0);
    sum_nxt = 24'(sum_r + 24'(flow));
    tick_nxt = tick_r + 7'd1;
    fold_num = {1'b0, sum_nxt} + 25'd8;
    level = {in_level_high_byte, in_level_low_byte};
    fuel_c = level;
    cap_c = '0;
    adapter_c = 1'b1;
    full_c = full_level_r;
    if (in_cartridge_model == ffg_pkg::MODEL_SMALL && in_data_revision == ffg_pkg::REV_5ML) begin
      fuel_c = 16'(in_old_level_byte * 16'd5);
      cap_c = 15'd230;
      adapter_c = 1'b0;
    end else if (in_cartridge_model == ffg_pkg::MODEL_SMALL &&
                 in_data_revision == ffg_pkg::REV_1ML) begin
      cap_c = 15'd230; full_c = 17'd230; adapter_c = 1'b0;
    end else if (in_cartridge_model == ffg_pkg::MODEL_2) begin
      cap_c = 15'd3500; full_c = 17'd3500;
    end else if (in_cartridge_model == ffg_pkg::MODEL_3) begin
      cap_c = 15'd17500; full_c = 17'd17500;
    end else if (in_cartridge_model == ffg_pkg::MODEL_5) begin
      cap_c = 15'd1200; full_c = 17'd1200; adapter_c = 1'b0;
    end else if (in_cartridge_model == ffg_pkg::MODEL_6) begin
      cap_c = 15'd550; full_c = 17'd550; adapter_c = 1'b0;
    end else if (in_cartridge_model == ffg_pkg::MODEL_7) begin
      cap_c = 15'd7000; full_c = 17'd7000;
    end else if (in_cartridge_model == ffg_pkg::MODEL_8) begin
      cap_c = 15'd3500; full_c = 17'd3500;
    end else if (in_cartridge_model == ffg_pkg::MODEL_LARGE) begin
      cap_c = 15'd10500;
      if (cfg.splitter_present) begin
        if (cfg.large_tank_level_option == ffg_pkg::OPT_FIXED) begin
          full_c = 17'd10500;
        end else if (cfg.large_tank_level_option == ffg_pkg::OPT_ADD_ON) begin
          full_c = {1'b0, level} + 17'd10500;
        end else begin
          full_c = 17'd21000;
        end
      end else begin
        full_c = (cfg.large_tank_level_option == ffg_pkg::OPT_FIXED) ? 17'd10500 : 17'd3500;
      end
    end else if (in_cartridge_model == ffg_pkg::MODEL_10) begin
      cap_c = 15'd6000; full_c = 17'd6000;
    end else if (in_cartridge_model == ffg_pkg::MODEL_11) begin
      cap_c = 15'd20000; full_c = 17'd20000;
    end else begin
      fuel_c = '0;
      full_c = '0;
    end
  end

  always_comb begin
    fold_prod = 38'(fold_num_r[24:6]) * 38'(FOLD_RECIP);
    gu = gauge_units_r + 32'(fold_q_r);
    du = display_units_r + 32'(fold_q_r);
    pct_num = 23'(fuel_r) * 23'd100;
    done_c = pending_r && ((model_r != ffg_pkg::MODEL_LARGE && pct_r > 8'd99) ||
                           (model_r == ffg_pkg::MODEL_LARGE && pct_r > 8'd32));
    clr_c = err_r && (pct_r >= 8'd20);
  end

  always_comb begin
    div_req = '0;
    if (state_r == S_UNITS && cap_r != '0) begin
      div_req.start = 1'b1;
      div_req.num = {pct_num, 25'd0};
      div_req.den = 27'(cap_r);
      div_req.steps = 6'd23;
    end else if (state_r == S_RTGO) begin
      div_req.start = 1'b1;
      div_req.num = {20'd0, fuel_r, 12'd0} + p2_r;
      div_req.den = 27'(pump_r) * 27'd2000;
      div_req.steps = 6'd48;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      finish_r <= 1'b0;
      out_valid <= 1'b0;
      sum_r <= '0;
      tick_r <= '0;
      gauge_units_r <= '0;
      display_units_r <= '0;
      dispensed_r <= '0;
      avg_r <= '0;
      full_level_r <= '0;
    end else begin
      if (finish_r && (!out_valid || !out_stall)) begin
        finish_r <= 1'b0;
        out_valid <= 1'b1;
        out_decrement_fuel <= dec_r;
        out_dispensed_count <= dispensed_r;
        out_fuel_left <= fuel_r;
        out_percent_left <= pct_r;
        out_full_level <= full_level_r;
        out_adapter_used <= adapter_r;
        out_large_cartridge <= model_r > ffg_pkg::MODEL_7;
        out_reprogram_done <= done_c;
        out_clear_empty_error <= clr_c;
        out_runtime_left <= avg_r;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            pump_r <= in_pump_flow;
            model_r <= in_cartridge_model;
            rev_r <= in_data_revision;
            pending_r <= in_reprogram_pending;
            err_r <= in_empty_error_set;
            fuel_r <= fuel_c;
            cap_r <= cap_c;
            adapter_r <= adapter_c;
            full_level_r <= full_c;
            if (tick_nxt == TICKS) begin
              sum_r <= '0;
              tick_r <= '0;
              fold_num_r <= fold_num;
              state_r <= S_FOLD;
            end else begin
              sum_r <= sum_nxt;
              tick_r <= tick_nxt;
              fold_q_r <= '0;
              state_r <= S_UNITS;
            end
          end
        end
        S_FOLD: begin
          fold_q_r <= fold_prod[36:22];
          state_r <= S_UNITS;
        end
        S_UNITS: begin
          dec_r <= 1'b0;
          gauge_units_r <= gu;
          if (rev_r == ffg_pkg::REV_5ML && gu > 32'd50000) begin
            gauge_units_r <= gu - 32'd50000;
            dec_r <= 1'b1;
          end
          if (rev_r == ffg_pkg::REV_1ML && gu > 32'd10000) begin
            gauge_units_r <= gu - 32'd10000;
            dec_r <= 1'b1;
          end
          display_units_r <= du;
          if (du > 32'd200) begin
            display_units_r <= du - 32'd200;
            dispensed_r <= dispensed_r + 24'd1;
          end
          state_r <= S_PCT;
        end
        S_PCT: begin
          if (cap_r == '0 || div_rsp.done) begin
            if (cap_r == '0) begin
              pct_r <= 8'd0;
            end else if (div_rsp.quot[22:0] > 23'd255) begin
              pct_r <= 8'd255;
            end else begin
              pct_r <= div_rsp.quot[7:0];
            end
            if (pump_r == '0) begin
              avg_r <= '0;
              finish_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          p1_r <= 32'(avg_r) * 32'd1999;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          p2_r <= 48'(p1_r) * 48'(pump_r);
          state_r <= S_RTGO;
        end
        S_RTGO: begin
          state_r <= S_RT;
        end
        S_RT: begin
          if (div_rsp.done) begin
            if (div_rsp.quot > 48'(RUNTIME_MAX)) begin
              avg_r <= RUNTIME_MAX;
            end else begin
              avg_r <= div_rsp.quot[20:0];
            end
            finish_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
